[hdl/pulse_saw_sound_generator_core_assert.svh]
// Assertion macros for the pulse/saw sound generator core.
`ifndef PULSE_SAW_SOUND_GENERATOR_CORE_ASSERT_SVH
`define PULSE_SAW_SOUND_GENERATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define PSG_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("psg: same-cycle check failed");

`define PSG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("psg: next-cycle check failed");

`else

`define PSG_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define PSG_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

[hdl/psg_pkg.sv]
// Shared types, constants and helpers for the pulse/saw sound generator.
`default_nettype none

package psg_pkg;

    localparam logic [15:0] DECODE_MASK  = 16'hF003;
    localparam logic [15:0] GLOBAL_ADDR  = 16'h9003;
    localparam logic [3:0]  PAGE_PULSE0  = 4'h9;
    localparam logic [3:0]  PAGE_PULSE1  = 4'hA;
    localparam logic [3:0]  PAGE_SAW     = 4'hB;
    localparam logic        CMD_WRITE    = 1'b0;
    localparam logic        CMD_TICK     = 1'b1;
    localparam logic [3:0]  SAW_LAST_STEP = 4'd13;

    localparam int PERIOD_W    = 12;
    localparam int COUNTDOWN_W = 13;

    typedef enum logic [1:0] {
        REG_CTRL      = 2'd0,
        REG_PERIOD_LO = 2'd1,
        REG_PERIOD_HI = 2'd2,
        REG_GLOBAL    = 2'd3
    } reg_sel_t;

    typedef enum logic [1:0] {
        SHIFT_0 = 2'd0,
        SHIFT_4 = 2'd1,
        SHIFT_8 = 2'd2
    } shift_t;

    // Per-channel request: a decoded write or a tick, already gated by the pipeline.
    typedef struct packed {
        logic       wr;
        reg_sel_t   sel;
        logic [7:0] data;
        logic       tick;
        shift_t     shift;
    } chan_req_t;

    function automatic logic [COUNTDOWN_W-1:0] reload_value(
        input logic [PERIOD_W-1:0] period,
        input shift_t              shift
    );
        logic [PERIOD_W-1:0] scaled;
        case (shift)
            SHIFT_4: scaled = period >> 4;
            SHIFT_8: scaled = period >> 8;
            default: scaled = period;
        endcase
        return {1'b0, scaled} + {{(COUNTDOWN_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

[hdl/psg_in_if.sv]
// Request channel: valid/ready handshake carrying one bus write or one tick.
`default_nettype none

interface psg_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, output command, output address, output data, input ready);
    modport sink   (input valid, input command, input address, input data, output ready);
endinterface

`default_nettype wire

[hdl/psg_out_if.sv]
// Result channel: valid/ready handshake carrying the channel levels and their sum.
`default_nettype none

interface psg_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] mix_level;
    logic [3:0] pulse_one_level;
    logic [3:0] pulse_two_level;
    logic [4:0] saw_level;

    modport source (output valid, output mix_level, output pulse_one_level,
                    output pulse_two_level, output saw_level, input ready);
    modport sink   (input valid, input mix_level, input pulse_one_level,
                    input pulse_two_level, input saw_level, output ready);
endinterface

`default_nettype wire

[hdl/psg_pulse.sv]
// Pulse channel: register file, period countdown, 16-step phase and level.
`default_nettype none

module psg_pulse (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psg_pkg::chan_req_t req,
    output logic [3:0]              level
);

    logic [3:0]                          volume_reg, volume_next;
    logic [2:0]                          duty_reg, duty_next;
    logic                                constant_reg, constant_next;
    logic [psg_pkg::PERIOD_W-1:0]        period_reg, period_next;
    logic                                on_reg, on_next;
    logic [psg_pkg::COUNTDOWN_W-1:0]     countdown_reg, countdown_next;
    logic [psg_pkg::COUNTDOWN_W-1:0]     countdown_dec;
    logic [3:0]                          phase_reg, phase_next;

    assign countdown_dec = countdown_reg - {{(psg_pkg::COUNTDOWN_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        volume_next    = volume_reg;
        duty_next      = duty_reg;
        constant_next  = constant_reg;
        period_next    = period_reg;
        on_next        = on_reg;
        countdown_next = countdown_reg;
        phase_next     = phase_reg;
        if (req.wr)
        begin
            unique case (req.sel)
                psg_pkg::REG_CTRL:
                begin
                    volume_next   = req.data[3:0];
                    duty_next     = req.data[6:4];
                    constant_next = req.data[7];
                end
                psg_pkg::REG_PERIOD_LO:
                begin
                    period_next = {period_reg[11:8], req.data};
                end
                psg_pkg::REG_PERIOD_HI:
                begin
                    period_next = {req.data[3:0], period_reg[7:0]};
                    on_next     = req.data[7];
                    // drop back to the first step on disable
                    if (!req.data[7])
                    begin
                        phase_next = 4'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (req.tick && on_reg)
        begin
            if (countdown_dec == '0)
            begin
                phase_next     = phase_reg + 4'd1;
                countdown_next = psg_pkg::reload_value(period_reg, req.shift);
            end
            else
            begin
                countdown_next = countdown_dec;
            end
        end
    end

    always_comb
    begin
        if (!on_next)
        begin
            level = 4'd0;
        end
        else if (constant_next || (phase_next <= {1'b0, duty_next}))
        begin
            level = volume_next;
        end
        else
        begin
            level = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg    <= 4'd0;
            duty_reg      <= 3'd0;
            constant_reg  <= 1'b0;
            period_reg    <= {{(psg_pkg::PERIOD_W-1){1'b0}}, 1'b1};
            on_reg        <= 1'b0;
            countdown_reg <= {{(psg_pkg::COUNTDOWN_W-1){1'b0}}, 1'b1};
            phase_reg     <= 4'd0;
        end
        else
        begin
            volume_reg    <= volume_next;
            duty_reg      <= duty_next;
            constant_reg  <= constant_next;
            period_reg    <= period_next;
            on_reg        <= on_next;
            countdown_reg <= countdown_next;
            phase_reg     <= phase_next;
        end
    end

endmodule

`default_nettype wire

[hdl/psg_saw.sv]
// Sawtooth channel: rate, period countdown, 14-step phase and 8-bit accumulator.
`default_nettype none

module psg_saw (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psg_pkg::chan_req_t req,
    output logic [4:0]              level,
    output logic                    enabled
);

    logic [5:0]                          rate_reg, rate_next;
    logic [7:0]                          accum_reg, accum_next;
    logic [psg_pkg::PERIOD_W-1:0]        period_reg, period_next;
    logic                                on_reg, on_next;
    logic [psg_pkg::COUNTDOWN_W-1:0]     countdown_reg, countdown_next;
    logic [psg_pkg::COUNTDOWN_W-1:0]     countdown_dec;
    logic [3:0]                          phase_reg, phase_next;
    logic [3:0]                          phase_inc;

    assign countdown_dec = countdown_reg - {{(psg_pkg::COUNTDOWN_W-1){1'b0}}, 1'b1};
    assign phase_inc     = (phase_reg == psg_pkg::SAW_LAST_STEP) ? 4'd0 : phase_reg + 4'd1;

    always_comb
    begin
        rate_next      = rate_reg;
        accum_next     = accum_reg;
        period_next    = period_reg;
        on_next        = on_reg;
        countdown_next = countdown_reg;
        phase_next     = phase_reg;
        if (req.wr)
        begin
            unique case (req.sel)
                psg_pkg::REG_CTRL:
                begin
                    rate_next = req.data[5:0];
                end
                psg_pkg::REG_PERIOD_LO:
                begin
                    period_next = {period_reg[11:8], req.data};
                end
                psg_pkg::REG_PERIOD_HI:
                begin
                    period_next = {req.data[3:0], period_reg[7:0]};
                    on_next     = req.data[7];
                    if (!req.data[7])
                    begin
                        accum_next = 8'd0;
                        phase_next = 4'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (req.tick && on_reg)
        begin
            if (countdown_dec == '0)
            begin
                phase_next     = phase_inc;
                countdown_next = psg_pkg::reload_value(period_reg, req.shift);
                // clear on wrap, add on the other even steps
                if (phase_inc == 4'd0)
                begin
                    accum_next = 8'd0;
                end
                else if (!phase_inc[0])
                begin
                    accum_next = accum_reg + {2'b00, rate_reg};
                end
            end
            else
            begin
                countdown_next = countdown_dec;
            end
        end
    end

    assign level   = on_next ? accum_next[7:3] : 5'd0;
    assign enabled = on_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= 6'd0;
            accum_reg     <= 8'd0;
            period_reg    <= {{(psg_pkg::PERIOD_W-1){1'b0}}, 1'b1};
            on_reg        <= 1'b0;
            countdown_reg <= {{(psg_pkg::COUNTDOWN_W-1){1'b0}}, 1'b1};
            phase_reg     <= 4'd0;
        end
        else
        begin
            rate_reg      <= rate_next;
            accum_reg     <= accum_next;
            period_reg    <= period_next;
            on_reg        <= on_next;
            countdown_reg <= countdown_next;
            phase_reg     <= phase_next;
        end
    end

endmodule

`default_nettype wire

[hdl/pulse_saw_sound_generator_core.sv]
// Top level of the pulse/saw sound generator: input stage, decode, channels, result register.
//
//   channel   direction   payload
//   cmd       sink        command, address, data
//   res       source      mix_level, pulse_one_level, pulse_two_level, saw_level
//
// One request per clock is sustained while res.ready stays high; a taken request passes
// the input register, then the channel update; its result is valid in the result register.
// Reset leaves every channel disabled, periods and countdowns at 1, not halted, no shift.
// A stalled result holds the result register; one more request still fills the
// input register, after which cmd.ready drops until the result is taken.
`default_nettype none

`include "pulse_saw_sound_generator_core_assert.svh"

module pulse_saw_sound_generator_core (
    input  wire logic clk,
    input  wire logic rst_n,
    psg_in_if.sink    cmd,
    psg_out_if.source res
);

    logic                s1_valid_reg;
    logic                s1_command_reg;
    logic [15:0]         s1_address_reg;
    logic [7:0]          s1_data_reg;
    logic                s2_load;

    logic [15:0]         decoded;
    logic                is_write;
    logic                global_wr;
    logic                tick;
    psg_pkg::chan_req_t  pulse0_req;
    psg_pkg::chan_req_t  pulse1_req;
    psg_pkg::chan_req_t  saw_req;

    logic                halted_reg, halted_next;
    psg_pkg::shift_t     shift_reg, shift_next;

    logic [3:0]          p1_level;
    logic [3:0]          p2_level;
    logic [4:0]          saw_lvl;
    logic                saw_on;

    logic                out_valid_reg;
    logic [5:0]          mix_reg;
    logic [3:0]          p1_reg;
    logic [3:0]          p2_reg;
    logic [4:0]          saw_reg;

    assign s2_load   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || s2_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_command_reg <= cmd.command;
            s1_address_reg <= cmd.address;
            s1_data_reg    <= cmd.data;
        end
    end

    // Decode the held request; everything is gated by the result-stage advance.
    assign decoded   = s1_address_reg & psg_pkg::DECODE_MASK;
    assign is_write  = s2_load && (s1_command_reg == psg_pkg::CMD_WRITE);
    assign global_wr = is_write && (decoded == psg_pkg::GLOBAL_ADDR);
    assign tick      = s2_load && (s1_command_reg == psg_pkg::CMD_TICK) && !halted_reg;

    always_comb
    begin
        pulse0_req.wr    = is_write && !global_wr && (decoded[15:12] == psg_pkg::PAGE_PULSE0);
        pulse0_req.sel   = psg_pkg::reg_sel_t'(decoded[1:0]);
        pulse0_req.data  = s1_data_reg;
        pulse0_req.tick  = tick;
        pulse0_req.shift = shift_reg;

        pulse1_req       = pulse0_req;
        pulse1_req.wr    = is_write && (decoded[15:12] == psg_pkg::PAGE_PULSE1);

        saw_req          = pulse0_req;
        saw_req.wr       = is_write && (decoded[15:12] == psg_pkg::PAGE_SAW);
    end

    always_comb
    begin
        halted_next = halted_reg;
        shift_next  = shift_reg;
        if (global_wr)
        begin
            halted_next = s1_data_reg[0];
            if (s1_data_reg[2])
            begin
                shift_next = psg_pkg::SHIFT_8;
            end
            else if (s1_data_reg[1])
            begin
                shift_next = psg_pkg::SHIFT_4;
            end
            else
            begin
                shift_next = psg_pkg::SHIFT_0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg <= 1'b0;
            shift_reg  <= psg_pkg::SHIFT_0;
        end
        else
        begin
            halted_reg <= halted_next;
            shift_reg  <= shift_next;
        end
    end

    psg_pulse u_pulse0 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pulse0_req),
        .level (p1_level)
    );

    psg_pulse u_pulse1 (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pulse1_req),
        .level (p2_level)
    );

    psg_saw u_saw (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (saw_req),
        .level   (saw_lvl),
        .enabled (saw_on)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            mix_reg <= {2'b00, p1_level} + {2'b00, p2_level} + {1'b0, saw_lvl};
            p1_reg  <= p1_level;
            p2_reg  <= p2_level;
            saw_reg <= saw_lvl;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.mix_level       = mix_reg;
    assign res.pulse_one_level = p1_reg;
    assign res.pulse_two_level = p2_reg;
    assign res.saw_level       = saw_reg;

    `PSG_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, !cmd.ready,
        s1_valid_reg && out_valid_reg && !res.ready)
    `PSG_ASSERT_IMPLIES(a_mix_is_sum, clk, rst_n, out_valid_reg,
        res.mix_level == ({2'b00, p1_reg} + {2'b00, p2_reg} + {1'b0, saw_reg}))
    `PSG_ASSERT_IMPLIES(a_saw_silent_when_off, clk, rst_n, out_valid_reg && !saw_on,
        res.saw_level == 5'd0)
    `PSG_ASSERT_NEXT(a_load_shows_result, clk, rst_n, s2_load, res.valid)

endmodule

`default_nettype wire
